FILE: hdl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, codes and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    // conversion kinds on the request
    localparam logic [2:0] CMD_UDEC = 3'd0;
    localparam logic [2:0] CMD_SDEC = 3'd1;
    localparam logic [2:0] CMD_HEX  = 3'd2;
    localparam logic [2:0] CMD_BIN  = 3'd3;
    localparam logic [2:0] CMD_PTR  = 3'd4;

    // digit engine kinds
    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_HEX = 2'd1;
    localparam logic [1:0] KIND_BIN = 2'd2;

    // prefix codes
    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_MINUS = 2'd1;
    localparam logic [1:0] PRE_ZERO  = 2'd2;
    localparam logic [1:0] PRE_X     = 2'd3;

    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_X     = 7'h78;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        is_wide;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_res;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] pre;
    } t_job_ctl;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = 7'h57 + {3'b000, d};   // 'a' - 10
        end
        return c;
    endfunction

endpackage

FILE: hdl/itaf_front.sv
// ----------------------------------------------------------------------------
// itaf_front
// Accepts requests, classifies them into kind, prefix and magnitude, and
// holds them in a short queue for the digit engine.
// ----------------------------------------------------------------------------
module itaf_front #(
    parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  itaf_pkg::t_req         i_req,
    output logic                   o_job_valid,
    output itaf_pkg::t_job_ctl     o_job,
    output logic [VALUE_WIDTH-1:0] o_job_mag,
    input  logic                   i_job_pop
);
    import itaf_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job_ctl               r_q_ctl [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0] r_q_mag [QUEUE_DEPTH];
    logic [QW-1:0]          r_wp, r_rp;
    logic [CW-1:0]          r_cnt;

    logic                   acc, push, pop;
    logic [VALUE_WIDTH-1:0] mask, v, v_neg, mag;
    logic                   sign;
    t_job_ctl               ctl;
    logic                   cmd_ok;

    assign busy = (r_cnt == CW'(QUEUE_DEPTH));
    assign acc  = start && !busy;

    always_comb begin
        mask   = i_req.is_wide ? '1 : VALUE_WIDTH'(32'hFFFF_FFFF);
        v      = i_req.value[VALUE_WIDTH-1:0] & mask;
        v_neg  = (~v + 1'b1) & mask;
        sign   = i_req.is_wide ? i_req.value[VALUE_WIDTH-1] : i_req.value[31];
        mag    = v;
        ctl    = '{kind: KIND_DEC, pre: PRE_NONE};
        cmd_ok = 1'b1;
        case (i_req.cmd)
            CMD_UDEC: begin
                mag = VALUE_WIDTH'(i_req.value[31:0]);
            end
            CMD_SDEC: begin
                if (sign) begin
                    mag     = v_neg;
                    ctl.pre = PRE_MINUS;
                end
            end
            CMD_HEX: begin
                ctl.kind = KIND_HEX;
            end
            CMD_BIN: begin
                ctl.kind = KIND_BIN;
            end
            CMD_PTR: begin
                mag = i_req.value[VALUE_WIDTH-1:0];
                ctl = '{kind: KIND_HEX, pre: PRE_ZERO};
            end
            default: begin
                cmd_ok = 1'b0;   // unknown kind prints nothing
            end
        endcase
    end

    assign push = acc && cmd_ok;
    assign pop  = i_job_pop && (r_cnt != '0);

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q_ctl[r_rp];
    assign o_job_mag   = r_q_mag[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_ctl[r_wp] <= ctl;
            r_q_mag[r_wp] <= mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/itaf_back.sv
// ----------------------------------------------------------------------------
// itaf_back
// Digit engine: emits the prefix, converts decimal by shift-and-add-3,
// skips leading zeros and sends one character per cycle.
// ----------------------------------------------------------------------------
module itaf_back #(
    parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_valid,
    input  itaf_pkg::t_job_ctl     i_job,
    input  logic [VALUE_WIDTH-1:0] i_job_mag,
    output logic                   o_job_pop,
    output logic                   o_valid,
    output itaf_pkg::t_res         o_res
);
    import itaf_pkg::*;

    localparam int BCD_DIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int SR_W    = BCD_DIG * 4;
    localparam int HEX_DIG = (VALUE_WIDTH + 3) / 4;
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRE  = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_kind, n_kind;
    logic [1:0]             r_pre, n_pre;
    logic [SR_W-1:0]        r_sr, n_sr;
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_valid, n_valid;
    t_res                   r_res, n_res;

    logic [SR_W-1:0]        adj, shifted;
    logic [3:0]             top;
    logic                   pop;

    always_comb begin
        for (int i = 0; i < BCD_DIG; i++) begin
            adj[4*i +: 4] = (r_sr[4*i +: 4] >= 4'd5) ? r_sr[4*i +: 4] + 4'd3
                                                     : r_sr[4*i +: 4];
        end
        top     = (r_kind == KIND_BIN) ? {3'b000, r_sr[SR_W-1]} : r_sr[SR_W-1 -: 4];
        shifted = (r_kind == KIND_BIN) ? (r_sr << 1) : (r_sr << 4);
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_pre   = r_pre;
        n_sr    = r_sr;
        n_bin   = r_bin;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_res   = r_res;
        pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    pop    = 1'b1;
                    n_kind = i_job.kind;
                    n_pre  = i_job.pre;
                    n_bin  = i_job_mag;
                    n_sr   = '0;
                    case (i_job.kind)
                        KIND_HEX: begin
                            n_sr[SR_W-1 -: HEX_DIG*4] = (HEX_DIG*4)'(i_job_mag);
                            n_cnt = CNT_W'(HEX_DIG);
                        end
                        KIND_BIN: begin
                            n_sr[SR_W-1 -: VALUE_WIDTH] = i_job_mag;
                            n_cnt = CNT_W'(VALUE_WIDTH);
                        end
                        default: begin
                            n_cnt = CNT_W'(VALUE_WIDTH);
                        end
                    endcase
                    if (i_job.pre != PRE_NONE) begin
                        n_state = ST_PRE;
                    end else if (i_job.kind == KIND_DEC) begin
                        n_state = ST_CONV;
                    end else begin
                        n_state = ST_SKIP;
                    end
                end
            end
            ST_PRE: begin
                n_valid         = 1'b1;
                n_res.last_char = 1'b0;
                case (r_pre)
                    PRE_ZERO:  n_res.out_char = CH_ZERO;
                    PRE_X:     n_res.out_char = CH_X;
                    default:   n_res.out_char = CH_MINUS;
                endcase
                if (r_pre == PRE_ZERO) begin
                    n_pre = PRE_X;
                end else begin
                    n_state = (r_kind == KIND_DEC) ? ST_CONV : ST_SKIP;
                end
            end
            ST_CONV: begin
                n_sr  = {adj[SR_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = r_bin << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(BCD_DIG);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (r_cnt > CNT_W'(1) && top == 4'd0) begin
                    n_sr  = shifted;
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_valid         = 1'b1;
                n_res.out_char  = digit_char(top);
                n_res.last_char = (r_cnt == CNT_W'(1));
                n_sr            = shifted;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_job_pop = pop;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pre  <= n_pre;
        r_sr   <= n_sr;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: hdl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer per request as printf-style ASCII text, one character
// per result, most significant digit first, last character marked.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  request   in         start && !busy        i_req  (cmd, is_wide, value)
//  result    out        o_valid, one cycle    o_res  (out_char, last_char)
//
//  Each request is loaded, then its prefix characters are sent. A decimal
//  value is next converted by shift-and-add-3 over all VALUE_WIDTH bits. In
//  every kind the leading zero digit positions are then skipped and the rest
//  printed, but at least one digit always appears, so zero prints as 0.
//  A two-entry queue sits between the front and the engine; busy is high while
//  it is full. Reset clears the queue and the engine. Results cannot be stalled.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  itaf_pkg::t_req i_req,
    output logic           o_valid,
    output itaf_pkg::t_res o_res
);
    import itaf_pkg::*;

    logic                   job_valid, job_pop;
    t_job_ctl               job;
    logic [VALUE_WIDTH-1:0] job_mag;

    itaf_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_job_valid (job_valid),
        .o_job       (job),
        .o_job_mag   (job_mag),
        .i_job_pop   (job_pop)
    );

    itaf_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_job_mag   (job_mag),
        .o_job_pop   (job_pop),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

endmodule

FILE: hdl/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks on the formatter's result stream.
// ----------------------------------------------------------------------------
module itaf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input itaf_pkg::t_res o_res
);
    import itaf_pkg::*;

    // first cycle out of reset shows no result
    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result right after reset");

    a_no_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.out_char != 7'h00)
        else $error("null character emitted");

    // pointer prefix: 'x' comes right after '0'
    a_x_after_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.out_char == CH_X) |->
            ($past(o_valid) && $past(o_res.out_char) == CH_ZERO && !$past(o_res.last_char)))
        else $error("'x' not preceded by '0'");

    // a prefix character never ends a number
    a_prefix_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.out_char == CH_X || o_res.out_char == CH_MINUS)) |->
            !o_res.last_char)
        else $error("prefix marked as last");

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);

FILE: dv/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// Sends conversion requests (directed edge values, then random traffic with
// varying sender gaps) and checks every emitted character and end marker
// against a local predictor of the printf-style text.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;
    import itaf_pkg::*;

    localparam int          VW             = VALUE_WIDTH_DEF;
    localparam logic [63:0] NARROW_MASK    = 64'h0000_0000_ffff_ffff;
    localparam logic [63:0] WIDE_MASK      = (VW == 64) ? '1 : ((64'd1 << VW) - 64'd1);
    localparam logic [6:0]  ASCII_LC_A     = 7'h61;
    localparam int          MAX_GAP        = 40;
    localparam int          TAIL_CYCLES    = 2 * VW + 16;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          REPORT_MAX     = 10;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_res o_res;

    t_res expected_chars[$];
    int   mismatch_count;
    int   stall_cycles;
    int   sender_idle_pct;

    integer_to_ascii_formatter #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic void push_char(logic [6:0] c);
        t_res r;
        r.out_char  = c;
        r.last_char = 1'b0;
        expected_chars.push_back(r);
    endfunction

    function automatic void push_digits(logic [63:0] mag, logic [63:0] radix);
        logic [6:0]  digs[64];
        logic [63:0] d;
        int          n;
        n = 0;
        if (mag == 64'd0) begin
            digs[0] = CH_ZERO;
            n = 1;
        end
        while (mag != 64'd0) begin
            d = mag % radix;
            digs[n] = (d < 64'd10) ? CH_ZERO + d[6:0] : ASCII_LC_A + d[6:0] - 7'd10;
            mag = mag / radix;
            n++;
        end
        for (int i = n - 1; i >= 0; i--) begin
            push_char(digs[i]);
        end
    endfunction

    function automatic void predict_text(t_req r);
        logic [63:0] mask;
        logic [63:0] v;
        int          w;
        int          before_len;
        t_res        tail;
        before_len = expected_chars.size();
        w    = r.is_wide ? VW : 32;
        mask = r.is_wide ? WIDE_MASK : NARROW_MASK;
        case (r.cmd)
            CMD_UDEC: push_digits(r.value & NARROW_MASK, 64'd10);
            CMD_SDEC: begin
                v = r.value & mask;
                if (v[w-1]) begin
                    push_char(CH_MINUS);
                    v = (~v + 64'd1) & mask;   // most negative keeps full magnitude
                end
                push_digits(v, 64'd10);
            end
            CMD_HEX:  push_digits(r.value & mask, 64'd16);
            CMD_BIN:  push_digits(r.value & mask, 64'd2);
            CMD_PTR: begin
                push_char(CH_ZERO);
                push_char(CH_X);
                push_digits(r.value & WIDE_MASK, 64'd16);
            end
            default: ;   // unknown kind: no text
        endcase
        if (expected_chars.size() > before_len) begin
            tail = expected_chars.pop_back();
            tail.last_char = 1'b1;
            expected_chars.push_back(tail);
        end
    endfunction

    // ---------------- checker and watchdog ----------------

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (o_valid) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: unexpected char %h last %b",
                                 $realtime, o_res.out_char, o_res.last_char);
                end else begin
                    want = expected_chars.pop_front();
                    if (o_res.out_char !== want.out_char ||
                        o_res.last_char !== want.last_char) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("%0t: char exp %h got %h, last exp %b got %b",
                                     $realtime, want.out_char, o_res.out_char,
                                     want.last_char, o_res.last_char);
                    end
                end
            end
            // a request and a result never meet in the same item, so check first
            if (start && !busy)
                predict_text(i_req);
            if (o_valid || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_request(logic [2:0] cmd, logic wide, logic [63:0] value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_req.cmd     <= cmd;
        i_req.is_wide <= wide;
        i_req.value   <= value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic test_field_extremes();
        send_request(CMD_UDEC, 1'b0, 64'd0);
        send_request(CMD_UDEC, 1'b0, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff);
        send_request(CMD_SDEC, 1'b0, 64'h0000_0000_7fff_ffff);
        send_request(CMD_HEX,  1'b1, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_HEX,  1'b0, 64'hdead_beef_0123_4567);
        send_request(CMD_BIN,  1'b1, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_BIN,  1'b0, 64'h5555_5555_aaaa_aaaa);
        send_request(CMD_PTR,  1'b1, 64'hfedc_ba98_7654_3210);
    endtask

    task automatic test_special_cases();
        // unsigned decimal ignores the wide flag and the upper word
        send_request(CMD_UDEC, 1'b1, 64'h1234_5678_0000_0009);
        // most negative values in both widths
        send_request(CMD_SDEC, 1'b1, 64'h8000_0000_0000_0000);
        send_request(CMD_SDEC, 1'b0, 64'hffff_ffff_8000_0000);
        send_request(CMD_SDEC, 1'b0, 64'h1234_5678_ffff_ffff);
        send_request(CMD_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff);
        send_request(CMD_SDEC, 1'b1, 64'd0);
        // zero prints one digit in every kind
        send_request(CMD_HEX,  1'b1, 64'd0);
        send_request(CMD_BIN,  1'b0, 64'hffff_ffff_0000_0000);
        send_request(CMD_PTR,  1'b0, 64'd0);
        // pointer ignores the wide flag
        send_request(CMD_PTR,  1'b0, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_unknown_kinds();
        send_request(3'd5, 1'b0, 64'd12345);
        send_request(3'd6, 1'b1, 64'hffff_ffff_ffff_ffff);
        send_request(3'd7, 1'b0, 64'd0);
        send_request(CMD_HEX, 1'b0, 64'h0000_0000_0000_00ab);
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        case ($urandom_range(5))
            0:       v = {$urandom, $urandom};
            1:       v = 64'($urandom_range(99));
            2:       v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
            3:       v = {32'($urandom), 32'h8000_0000 | 32'($urandom_range(3))};
            4:       v = 64'd0 - 64'($urandom_range(1000));
            default: v = {$urandom, 32'($urandom_range(9))};
        endcase
        return v;
    endfunction

    task automatic test_random_traffic(int idle_pct, int count);
        logic [2:0] cmd;
        int         sent;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(19) == 0)
                cmd = 3'($urandom_range(7, 5));
            else
                cmd = 3'($urandom_range(4));
            send_request(cmd, 1'($urandom_range(1)), random_value());
            if (cmd <= CMD_PTR)
                sent++;
        end
    endtask

    initial begin
        start           = 1'b0;
        i_req           = '0;
        i_rst_n         = 1'b0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        sender_idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_special_cases();
        test_unknown_kinds();
        wait_for_drain();

        test_random_traffic(0, 120);
        wait_for_drain();
        test_random_traffic(81, 100);
        test_random_traffic(16, 80);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
